// ===== rtl/mpfp_pkg.sv =====
// Types and constants shared by the mesh peering frame parser.
`timescale 1ns / 1ps
package mpfp_pkg;

	// Header layout
	localparam int HDR_LEN = 24;

	// Frame control: type/subtype check on the first byte
	localparam logic [7:0] FC_MASK   = 8'h0c | 8'hf0;
	localparam logic [7:0] FC_ACTION = 8'hd0;

	localparam logic [7:0] CAT_SELF_PROT = 8'd15;
	localparam logic [7:0] ACT_OPEN      = 8'd1;
	localparam logic [7:0] ACT_CONFIRM   = 8'd2;
	localparam logic [7:0] ACT_CLOSE     = 8'd3;
	localparam logic [7:0] EID_MESH_ID   = 8'd114;
	localparam logic [7:0] EID_PEER_MGMT = 8'd117;

	// Element walker phase
	localparam logic [1:0] PH_ID   = 2'd0;
	localparam logic [1:0] PH_LEN  = 2'd1;
	localparam logic [1:0] PH_BODY = 2'd2;

	// Element kind
	localparam logic [1:0] KIND_OTHER = 2'd0;
	localparam logic [1:0] KIND_MESH  = 2'd1;
	localparam logic [1:0] KIND_PEER  = 2'd2;

	// Result status codes
	localparam logic [3:0] ST_OK          = 4'd0;
	localparam logic [3:0] ST_SHORT       = 4'd1;
	localparam logic [3:0] ST_NOT_ACTION  = 4'd2;
	localparam logic [3:0] ST_CATEGORY    = 4'd3;
	localparam logic [3:0] ST_ACTION      = 4'd4;
	localparam logic [3:0] ST_FIXED_TRUNC = 4'd5;
	localparam logic [3:0] ST_ELEM_OVER   = 4'd6;
	localparam logic [3:0] ST_NO_PEER     = 4'd7;
	localparam logic [3:0] ST_PEER_LEN    = 4'd8;
	localparam logic [3:0] ST_TOO_LONG    = 4'd9;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} item_t;

	typedef struct packed {
		logic [3:0]  status;
		logic [7:0]  peer_action;
		logic [47:0] dest_addr;
		logic [47:0] src_addr;
		logic [15:0] assoc_id;
		logic [10:0] mesh_id_offset;
		logic [7:0]  mesh_id_length;
		logic [3:0]  peer_elem_length;
		logic [15:0] local_link_id;
		logic [15:0] peer_link_id;
		logic [15:0] close_reason;
	} result_t;

endpackage

// ===== rtl/mpfp_parse.sv =====
// Per-byte frame state and end-of-frame result decode.
`timescale 1ns / 1ps
module mpfp_parse
	import mpfp_pkg::*;
#(
	parameter int MAX_FRAME_LEN = 2048
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       en,
	input  logic [7:0] data_byte,
	input  logic       last_byte,
	output result_t    res
);

	localparam int IDXW = $clog2(MAX_FRAME_LEN + 2);
	localparam logic [IDXW-1:0] MAXC = IDXW'(MAX_FRAME_LEN);

	logic [IDXW-1:0] idx_q, idx_d;
	logic [7:0]      fc_q, fc_d;
	logic [7:0]      cat_q, cat_d;
	logic [7:0]      act_q, act_d;
	logic [47:0]     dest_q, dest_d;
	logic [47:0]     src_q, src_d;
	logic [15:0]     aid_q, aid_d;
	logic [1:0]      phase_q, phase_d;
	logic [7:0]      rem_q, rem_d;
	logic [1:0]      kind_q, kind_d;
	logic [10:0]     moff_q, moff_d;
	logic [7:0]      mlen_q, mlen_d;
	logic            pseen_q, pseen_d;
	logic [7:0]      plen_q, plen_d;
	logic [63:0]     pbody_q, pbody_d;

	logic            act_ok;
	logic [IDXW-1:0] fix_end;
	logic [IDXW:0]   idx_p1;
	logic [2:0]      dpos, spos;
	logic [7:0]      ppos;
	logic [3:0]      status;
	logic            act_ok_d;
	logic [IDXW-1:0] fix_end_d;
	logic [79:0]     pbody_ext;
	logic [2:0]      cr_pos;

	// Next state for one byte
	always_comb begin
		idx_d   = idx_q;
		fc_d    = fc_q;
		cat_d   = cat_q;
		act_d   = act_q;
		dest_d  = dest_q;
		src_d   = src_q;
		aid_d   = aid_q;
		phase_d = phase_q;
		rem_d   = rem_q;
		kind_d  = kind_q;
		moff_d  = moff_q;
		mlen_d  = mlen_q;
		pseen_d = pseen_q;
		plen_d  = plen_q;
		pbody_d = pbody_q;

		act_ok = (act_q == ACT_OPEN) || (act_q == ACT_CONFIRM) || (act_q == ACT_CLOSE);
		if (act_q == ACT_OPEN) begin
			fix_end = IDXW'(HDR_LEN + 4);
		end else if (act_q == ACT_CONFIRM) begin
			fix_end = IDXW'(HDR_LEN + 6);
		end else begin
			fix_end = IDXW'(HDR_LEN + 2);
		end
		idx_p1 = {1'b0, idx_q} + 1'b1;
		dpos   = 3'(idx_q - IDXW'(4));
		spos   = 3'(idx_q - IDXW'(10));
		ppos   = plen_q - rem_q;

		if (idx_q < MAXC) begin
			if (idx_q == '0) begin
				fc_d = data_byte;
			end else if (idx_q >= IDXW'(4) && idx_q < IDXW'(10)) begin
				dest_d[{dpos, 3'b000} +: 8] = data_byte;
			end else if (idx_q >= IDXW'(10) && idx_q < IDXW'(16)) begin
				src_d[{spos, 3'b000} +: 8] = data_byte;
			end else if (idx_q == IDXW'(HDR_LEN)) begin
				cat_d = data_byte;
			end else if (idx_q == IDXW'(HDR_LEN + 1)) begin
				act_d = data_byte;
			end else if (idx_q >= IDXW'(HDR_LEN + 2) && act_ok) begin
				if (idx_q < fix_end) begin
					if (act_q == ACT_CONFIRM && idx_q == IDXW'(HDR_LEN + 4)) begin
						aid_d[7:0] = data_byte;
					end else if (act_q == ACT_CONFIRM && idx_q == IDXW'(HDR_LEN + 5)) begin
						aid_d[15:8] = data_byte;
					end
				end else begin
					// element walker
					case (phase_q)
						PH_ID: begin
							if (data_byte == EID_MESH_ID) begin
								kind_d = KIND_MESH;
							end else if (data_byte == EID_PEER_MGMT) begin
								kind_d = KIND_PEER;
							end else begin
								kind_d = KIND_OTHER;
							end
							phase_d = PH_LEN;
						end
						PH_LEN: begin
							if (kind_q == KIND_MESH) begin
								moff_d = 11'(idx_p1);
								mlen_d = data_byte;
							end else if (kind_q == KIND_PEER) begin
								pseen_d = 1'b1;
								plen_d  = data_byte;
								pbody_d = '0;
							end
							rem_d   = data_byte;
							phase_d = (data_byte != 8'd0) ? PH_BODY : PH_ID;
						end
						default: begin
							if (kind_q == KIND_PEER && ppos < 8'd8) begin
								pbody_d[{ppos[2:0], 3'b000} +: 8] = data_byte;
							end
							rem_d = rem_q - 8'd1;
							if (rem_d == 8'd0) begin
								phase_d = PH_ID;
							end
						end
					endcase
				end
			end
		end
		if (idx_q <= MAXC) begin
			idx_d = IDXW'(idx_p1);
		end
	end

	// End-of-frame status, checked in priority order on the updated state
	always_comb begin
		act_ok_d = (act_d == ACT_OPEN) || (act_d == ACT_CONFIRM) || (act_d == ACT_CLOSE);
		if (act_d == ACT_OPEN) begin
			fix_end_d = IDXW'(HDR_LEN + 4);
		end else if (act_d == ACT_CONFIRM) begin
			fix_end_d = IDXW'(HDR_LEN + 6);
		end else begin
			fix_end_d = IDXW'(HDR_LEN + 2);
		end

		if (idx_d > MAXC) begin
			status = ST_TOO_LONG;
		end else if (idx_d < IDXW'(HDR_LEN + 2)) begin
			status = ST_SHORT;
		end else if ((fc_d & FC_MASK) != FC_ACTION) begin
			status = ST_NOT_ACTION;
		end else if (cat_d != CAT_SELF_PROT) begin
			status = ST_CATEGORY;
		end else if (!act_ok_d) begin
			status = ST_ACTION;
		end else if (idx_d < fix_end_d) begin
			status = ST_FIXED_TRUNC;
		end else if (phase_d == PH_BODY && rem_d != 8'd0) begin
			status = ST_ELEM_OVER;
		end else if (!pseen_d) begin
			status = ST_NO_PEER;
		end else if (act_d == ACT_OPEN && plen_d != 8'd4) begin
			status = ST_PEER_LEN;
		end else if (act_d == ACT_CONFIRM && plen_d != 8'd6) begin
			status = ST_PEER_LEN;
		end else if (act_d == ACT_CLOSE && plen_d != 8'd6 && plen_d != 8'd8) begin
			status = ST_PEER_LEN;
		end else begin
			status = ST_OK;
		end

		pbody_ext = {16'h0000, pbody_d};
		cr_pos    = 3'(plen_d - 8'd2);

		res        = '0;
		res.status = status;
		if (status == ST_OK) begin
			res.peer_action      = act_d;
			res.dest_addr        = dest_d;
			res.src_addr         = src_d;
			res.assoc_id         = (act_d == ACT_CONFIRM) ? aid_d : 16'h0000;
			res.mesh_id_offset   = moff_d;
			res.mesh_id_length   = mlen_d;
			res.peer_elem_length = plen_d[3:0];
			if (act_d == ACT_CONFIRM || (act_d == ACT_CLOSE && plen_d == 8'd8)) begin
				res.local_link_id = pbody_d[47:32];
			end
			res.peer_link_id = pbody_d[31:16];
			if (act_d == ACT_CLOSE) begin
				res.close_reason = pbody_ext[{cr_pos, 3'b000} +: 16];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			fc_q    <= '0;
			cat_q   <= '0;
			act_q   <= '0;
			dest_q  <= '0;
			src_q   <= '0;
			aid_q   <= '0;
			phase_q <= PH_ID;
			rem_q   <= '0;
			kind_q  <= KIND_OTHER;
			moff_q  <= '0;
			mlen_q  <= '0;
			pseen_q <= 1'b0;
			plen_q  <= '0;
			pbody_q <= '0;
		end else if (en) begin
			if (last_byte) begin
				// frame done: back to the idle frame state
				idx_q   <= '0;
				fc_q    <= '0;
				cat_q   <= '0;
				act_q   <= '0;
				dest_q  <= '0;
				src_q   <= '0;
				aid_q   <= '0;
				phase_q <= PH_ID;
				rem_q   <= '0;
				kind_q  <= KIND_OTHER;
				moff_q  <= '0;
				mlen_q  <= '0;
				pseen_q <= 1'b0;
				plen_q  <= '0;
				pbody_q <= '0;
			end else begin
				idx_q   <= idx_d;
				fc_q    <= fc_d;
				cat_q   <= cat_d;
				act_q   <= act_d;
				dest_q  <= dest_d;
				src_q   <= src_d;
				aid_q   <= aid_d;
				phase_q <= phase_d;
				rem_q   <= rem_d;
				kind_q  <= kind_d;
				moff_q  <= moff_d;
				mlen_q  <= mlen_d;
				pseen_q <= pseen_d;
				plen_q  <= plen_d;
				pbody_q <= pbody_d;
			end
		end
	end

endmodule

// ===== rtl/mesh_peering_frame_parser.sv =====
// Top level of the 802.11s mesh peering frame parser.
`timescale 1ns / 1ps
// Throughput: one frame byte per cycle, no gaps between frames, but for the
// hold-off below. Result path: the last byte enters the input register, and
// its decode is then loaded into the result register.
// A pending result holds off new bytes only when the last byte of the next
// frame reaches the decode stage. Reset (arst_n low) empties both registers
// and returns the parser to the start-of-frame state.
module mesh_peering_frame_parser
	import mpfp_pkg::*;
#(
	parameter int MAX_FRAME_LEN = 2048
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    item_valid,
	output logic    item_ready,
	input  item_t   item,
	output logic    result_valid,
	input  logic    result_ready,
	output result_t result
);

	// Input register stage
	logic    valid_s1;
	item_t   item_s1;

	// Result register
	logic    result_valid_q;
	result_t result_q;

	result_t res_s1;
	logic    advance;
	logic    take_byte;

	// Stage 1 may move on unless it holds a last byte while the result
	// register is full and not being drained.
	assign advance   = !valid_s1 || !item_s1.last_byte || !result_valid_q || result_ready;
	assign take_byte = valid_s1 && advance;
	assign item_ready = advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && item_valid) begin
			item_s1 <= item;
		end
	end

	// Frame state and end-of-frame decode
	mpfp_parse #(
		.MAX_FRAME_LEN(MAX_FRAME_LEN)
	) u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (take_byte),
		.data_byte (item_s1.data_byte),
		.last_byte (item_s1.last_byte),
		.res       (res_s1)
	);

	// Result register: loaded on the last byte, cleared by a transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (take_byte && item_s1.last_byte) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take_byte && item_s1.last_byte) begin
			result_q <= res_s1;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench for the mesh peering frame parser.
`timescale 1ns / 1ps

import mpfp_pkg::*;

// Frame decoder mirror: follows every byte transfer and queues the decode
// that the last byte of each frame should produce.
class frame_decode_check #(int MAX_LEN = 2048);
	int unsigned byte_count;
	logic [7:0]  fc_low;
	logic [7:0]  cat;
	logic [7:0]  act;
	logic [47:0] da;
	logic [47:0] sa;
	logic [15:0] aid;
	logic [1:0]  phase;
	logic [7:0]  remain;
	logic [1:0]  kind;
	int unsigned mesh_off;
	logic [7:0]  mesh_len;
	bit          peer_seen;
	logic [7:0]  peer_len;
	logic [63:0] peer_body;
	result_t     pending_decodes[$];
	int          errors;

	function new();
		errors = 0;
		clear();
	endfunction

	function void clear();
		byte_count = 0;
		fc_low = '0;
		cat = '0;
		act = '0;
		da = '0;
		sa = '0;
		aid = '0;
		phase = PH_ID;
		remain = '0;
		kind = KIND_OTHER;
		mesh_off = 0;
		mesh_len = '0;
		peer_seen = 1'b0;
		peer_len = '0;
		peer_body = '0;
	endfunction

	function int pending();
		return pending_decodes.size();
	endfunction

	function bit action_ok();
		return act == ACT_OPEN || act == ACT_CONFIRM || act == ACT_CLOSE;
	endfunction

	function int unsigned fixed_end();
		if (act == ACT_OPEN)
			return HDR_LEN + 4;
		if (act == ACT_CONFIRM)
			return HDR_LEN + 6;
		return HDR_LEN + 2;
	endfunction

	function logic [15:0] body16(int unsigned pos);
		logic [63:0] s;
		s = peer_body >> (8 * (pos % 8));
		return s[15:0];
	endfunction

	function void walk_element(int unsigned i, logic [7:0] b);
		logic [7:0] pos;
		case (phase)
			PH_ID: begin
				kind = (b == EID_MESH_ID) ? KIND_MESH :
					(b == EID_PEER_MGMT) ? KIND_PEER : KIND_OTHER;
				phase = PH_LEN;
			end
			PH_LEN: begin
				if (kind == KIND_MESH) begin
					mesh_off = i + 1;
					mesh_len = b;
				end else if (kind == KIND_PEER) begin
					peer_seen = 1'b1;
					peer_len = b;
					peer_body = '0;
				end
				remain = b;
				phase = (b != 8'd0) ? PH_BODY : PH_ID;
			end
			default: begin
				if (kind == KIND_PEER) begin
					pos = peer_len - remain;
					if (pos < 8'd8)
						peer_body[8 * pos +: 8] = b;
				end
				remain = remain - 8'd1;
				if (remain == 8'd0)
					phase = PH_ID;
			end
		endcase
	endfunction

	function void absorb(int unsigned i, logic [7:0] b);
		if (i == 0)
			fc_low = b;
		else if (i >= 4 && i < 10)
			da[8 * (i - 4) +: 8] = b;
		else if (i >= 10 && i < 16)
			sa[8 * (i - 10) +: 8] = b;
		else if (i == HDR_LEN)
			cat = b;
		else if (i == HDR_LEN + 1)
			act = b;
		else if (i >= HDR_LEN + 2 && action_ok()) begin
			if (i < fixed_end()) begin
				if (act == ACT_CONFIRM && i == HDR_LEN + 4)
					aid[7:0] = b;
				else if (act == ACT_CONFIRM && i == HDR_LEN + 5)
					aid[15:8] = b;
			end else begin
				walk_element(i, b);
			end
		end
	endfunction

	function logic [3:0] frame_status(int unsigned len);
		if (len > MAX_LEN) return ST_TOO_LONG;
		if (len < HDR_LEN + 2) return ST_SHORT;
		if ((fc_low & FC_MASK) != FC_ACTION) return ST_NOT_ACTION;
		if (cat != CAT_SELF_PROT) return ST_CATEGORY;
		if (!action_ok()) return ST_ACTION;
		if (len < fixed_end()) return ST_FIXED_TRUNC;
		if (phase == PH_BODY && remain != 0) return ST_ELEM_OVER;
		if (!peer_seen) return ST_NO_PEER;
		if (act == ACT_OPEN && peer_len != 4) return ST_PEER_LEN;
		if (act == ACT_CONFIRM && peer_len != 6) return ST_PEER_LEN;
		if (act == ACT_CLOSE && peer_len != 6 && peer_len != 8) return ST_PEER_LEN;
		return ST_OK;
	endfunction

	function void take_byte(item_t it);
		int unsigned i;
		logic [3:0]  st;
		result_t     r;
		i = byte_count;
		if (i < MAX_LEN)
			absorb(i, it.data_byte);
		if (byte_count <= MAX_LEN)
			byte_count++;
		if (!it.last_byte)
			return;
		st = frame_status(byte_count);
		r = '0;
		r.status = st;
		if (st == ST_OK) begin
			r.peer_action = act;
			r.dest_addr = da;
			r.src_addr = sa;
			r.assoc_id = (act == ACT_CONFIRM) ? aid : 16'h0;
			r.mesh_id_offset = mesh_off[10:0];
			r.mesh_id_length = mesh_len;
			r.peer_elem_length = peer_len[3:0];
			if (act == ACT_CONFIRM || (act == ACT_CLOSE && peer_len == 8))
				r.local_link_id = body16(4);
			r.peer_link_id = body16(2);
			if (act == ACT_CLOSE)
				r.close_reason = body16(peer_len - 2);
		end
		pending_decodes.push_back(r);
		clear();
	endfunction

	function void cmp_field(string name, logic [63:0] want, logic [63:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, actual %0h", name, want, got);
			errors++;
		end
	endfunction

	function void check_decode(result_t r);
		result_t w;
		if (pending_decodes.size() == 0) begin
			$error("decode with no frame pending: status %0d", r.status);
			errors++;
			return;
		end
		w = pending_decodes.pop_front();
		cmp_field("status", w.status, r.status);
		cmp_field("peer_action", w.peer_action, r.peer_action);
		cmp_field("dest_addr", w.dest_addr, r.dest_addr);
		cmp_field("src_addr", w.src_addr, r.src_addr);
		cmp_field("assoc_id", w.assoc_id, r.assoc_id);
		cmp_field("mesh_id_offset", w.mesh_id_offset, r.mesh_id_offset);
		cmp_field("mesh_id_length", w.mesh_id_length, r.mesh_id_length);
		cmp_field("peer_elem_length", w.peer_elem_length, r.peer_elem_length);
		cmp_field("local_link_id", w.local_link_id, r.local_link_id);
		cmp_field("peer_link_id", w.peer_link_id, r.peer_link_id);
		cmp_field("close_reason", w.close_reason, r.close_reason);
	endfunction
endclass

module testbench;

	localparam int FRAME_LIMIT    = 2048;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int HOLD_CYCLES    = 400;

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    item_valid = 1'b0;
	logic    item_ready;
	item_t   item = '0;
	logic    result_valid;
	logic    result_ready = 1'b0;
	result_t result;

	frame_decode_check #(FRAME_LIMIT) decode_chk;

	// Frame under construction, sent byte by byte.
	logic [7:0]  frame_buf[$];
	int unsigned bytes_sent = 0;
	int unsigned random_frames = 0;
	// Percent of cycles in which each side sits idle.
	int unsigned idle_pct = 16;
	// Receiver hold-off request; the receiver counts the stretch itself.
	bit          hold_request = 0;
	int unsigned stall_cycles = 0;

	mesh_peering_frame_parser #(
		.MAX_FRAME_LEN(FRAME_LIMIT)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.item(item),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result(result)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Receiver: random ready at the falling edge, plus one long hold-off.
	int unsigned hold_left = 0;
	bit          hold_taken = 0;
	always @(negedge clk) begin
		if (!arst_n) begin
			result_ready = 1'b0;
		end else begin
			if (hold_request && !hold_taken) begin
				hold_taken = 1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				result_ready = 1'b0;
				hold_left--;
			end else begin
				result_ready = ($urandom_range(0, 99) >= idle_pct);
			end
		end
	end

	// Result monitor: a transfer is taken at the rising edge.
	always @(posedge clk) begin
		if (arst_n && result_valid && result_ready)
			decode_chk.check_decode(result);
	end

	// Watchdog: cycles in which neither channel moves a transfer.
	always @(posedge clk) begin
		if ((item_valid && item_ready) || (result_valid && result_ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
	end

	initial begin
		wait (stall_cycles >= WATCHDOG_LIMIT);
		$display("Simulation FAILED");
		$finish;
	end

	// Offer one byte from a falling edge; return at the falling edge after
	// its transfer with valid still high, so back-to-back bytes never drop it.
	task automatic send_byte(input logic [7:0] b, input logic l);
		while ($urandom_range(0, 99) < idle_pct) begin
			item_valid = 1'b0;
			@(negedge clk);
		end
		item_valid = 1'b1;
		item = '{b, l};
		do
			@(posedge clk);
		while (!item_ready);
		decode_chk.take_byte(item);
		@(negedge clk);
	endtask

	task automatic send_frame();
		for (int k = 0; k < frame_buf.size(); k++)
			send_byte(frame_buf[k], k == frame_buf.size() - 1);
		bytes_sent += frame_buf.size();
	endtask

	// Sender goes quiet until every decode has come back.
	task automatic drain();
		item_valid = 1'b0;
		while (decode_chk.pending() != 0)
			@(negedge clk);
	endtask

	function automatic logic [7:0] other_id();
		logic [7:0] v;
		do
			v = 8'($urandom_range(0, 255));
		while (v == EID_MESH_ID || v == EID_PEER_MGMT);
		return v;
	endfunction

	// 24-byte header with the type/subtype of an action frame (the two
	// unchecked low bits random), category, action and its fixed fields.
	task automatic start_header(input logic [7:0] a);
		frame_buf.delete();
		frame_buf.push_back(FC_ACTION | 8'($urandom_range(0, 3)));
		repeat (HDR_LEN - 1)
			frame_buf.push_back(8'($urandom_range(0, 255)));
		frame_buf.push_back(CAT_SELF_PROT);
		frame_buf.push_back(a);
		if (a == ACT_OPEN)
			repeat (2) frame_buf.push_back(8'($urandom_range(0, 255)));
		else if (a == ACT_CONFIRM)
			repeat (4) frame_buf.push_back(8'($urandom_range(0, 255)));
	endtask

	task automatic add_element(input logic [7:0] id, input int unsigned len);
		frame_buf.push_back(id);
		frame_buf.push_back(8'(len));
		repeat (len)
			frame_buf.push_back(8'($urandom_range(0, 255)));
	endtask

	task automatic truncate_to(input int unsigned n);
		while (frame_buf.size() > n)
			void'(frame_buf.pop_back());
	endtask

	task automatic set_addresses(input logic [7:0] v);
		for (int k = 4; k < 16; k++)
			frame_buf[k] = v;
	endtask

	// Pad with unknown elements up to byte n.
	task automatic fill_to(input int unsigned n);
		int unsigned rem;
		while (frame_buf.size() < n) begin
			rem = n - frame_buf.size();
			if (rem >= 257)
				add_element(other_id(), 255);
			else if (rem >= 2)
				add_element(other_id(), rem - 2);
			else
				frame_buf.push_back(8'($urandom_range(0, 255)));
		end
	endtask

	// Mostly well-formed peering frames with random content; about a
	// third carry one fault or are plain noise.
	task automatic build_random_frame();
		logic [7:0]  a;
		int unsigned plen;
		int unsigned n_other;
		int unsigned peer_at;
		int unsigned fault;
		int unsigned len;
		a = 8'($urandom_range(1, 3));
		fault = ($urandom_range(0, 99) < 30) ? $urandom_range(1, 8) : 0;
		start_header(a);
		plen = (a == ACT_OPEN) ? 4 : (a == ACT_CONFIRM) ? 6 : ($urandom_range(0, 1) ? 8 : 6);
		if (fault == 1)
			plen = $urandom_range(0, 12);
		n_other = $urandom_range(0, 3);
		peer_at = $urandom_range(0, n_other);
		for (int k = 0; k <= n_other; k++) begin
			if (k == peer_at && fault != 2)
				add_element(EID_PEER_MGMT, plen);
			if (k < n_other) begin
				if ($urandom_range(0, 2) == 0)
					add_element(EID_MESH_ID, $urandom_range(0, 32));
				else
					add_element(other_id(), $urandom_range(0, 12));
			end
		end
		// a second peer element replaces the first
		if (fault != 2 && $urandom_range(0, 9) == 0)
			add_element(EID_PEER_MGMT, plen);
		if ($urandom_range(0, 9) == 0)
			frame_buf.push_back(8'($urandom_range(0, 255)));
		case (fault)
			3: frame_buf[0] = 8'($urandom_range(0, 255));
			4: frame_buf[HDR_LEN] = 8'($urandom_range(0, 255));
			5: frame_buf[HDR_LEN + 1] = 8'($urandom_range(0, 255));
			6: truncate_to($urandom_range(1, frame_buf.size() - 1));
			7: begin
				// element body cut off by the end of the frame
				len = $urandom_range(2, 20);
				frame_buf.push_back(other_id());
				frame_buf.push_back(8'(len));
				repeat ($urandom_range(0, len - 1))
					frame_buf.push_back(8'($urandom_range(0, 255)));
			end
			8: begin
				frame_buf.delete();
				repeat ($urandom_range(1, 40))
					frame_buf.push_back(8'($urandom_range(0, 255)));
			end
			default: ;
		endcase
	endtask

	task automatic run_random(input int unsigned upto, input int unsigned min_frames);
		while (bytes_sent < upto || random_frames < min_frames) begin
			build_random_frame();
			send_frame();
			random_frames++;
		end
	endtask

	int unsigned base;

	initial begin
		decode_chk = new();
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// --- directed frames ---
		// one-byte frame, then a 25-byte one: both too short
		start_header(ACT_OPEN);
		truncate_to(1);
		send_frame();
		start_header(ACT_OPEN);
		truncate_to(HDR_LEN + 1);
		send_frame();

		// data frame type, wrong category, bad action codes
		start_header(ACT_OPEN);
		add_element(EID_PEER_MGMT, 4);
		frame_buf[0] = 8'h08;
		send_frame();
		start_header(ACT_OPEN);
		add_element(EID_PEER_MGMT, 4);
		frame_buf[HDR_LEN] = 8'h00;
		send_frame();
		start_header(ACT_CLOSE);
		add_element(EID_PEER_MGMT, 6);
		frame_buf[HDR_LEN + 1] = 8'h00;
		send_frame();
		start_header(ACT_CLOSE);
		add_element(EID_PEER_MGMT, 6);
		frame_buf[HDR_LEN + 1] = 8'hff;
		send_frame();

		// fixed fields cut short for open and confirm
		start_header(ACT_OPEN);
		truncate_to(HDR_LEN + 3);
		send_frame();
		start_header(ACT_CONFIRM);
		truncate_to(HDR_LEN + 5);
		send_frame();

		// good open, all-ones addresses and both free FC bits set
		start_header(ACT_OPEN);
		frame_buf[0] = FC_ACTION | 8'h03;
		set_addresses(8'hff);
		add_element(EID_MESH_ID, 32);
		add_element(EID_PEER_MGMT, 4);
		send_frame();

		// good confirm, zero addresses; last Mesh ID and last peer element win
		start_header(ACT_CONFIRM);
		set_addresses(8'h00);
		add_element(EID_MESH_ID, 5);
		add_element(EID_PEER_MGMT, 6);
		add_element(EID_MESH_ID, 3);
		add_element(other_id(), 0);
		add_element(EID_PEER_MGMT, 6);
		send_frame();

		// close with a 6-byte and an 8-byte peer body; the 8-byte one has a
		// trailing single byte that cannot hold an element header
		start_header(ACT_CLOSE);
		add_element(EID_PEER_MGMT, 6);
		send_frame();
		start_header(ACT_CLOSE);
		add_element(EID_PEER_MGMT, 8);
		frame_buf.push_back(EID_MESH_ID);
		send_frame();

		// element overrun, no peer element, oversized and empty peer bodies
		start_header(ACT_OPEN);
		add_element(EID_PEER_MGMT, 4);
		add_element(EID_PEER_MGMT, 6);
		truncate_to(frame_buf.size() - 3);
		send_frame();
		start_header(ACT_CONFIRM);
		add_element(EID_MESH_ID, 4);
		send_frame();
		start_header(ACT_CLOSE);
		add_element(EID_PEER_MGMT, 10);
		send_frame();
		start_header(ACT_OPEN);
		add_element(EID_PEER_MGMT, 0);
		send_frame();

		// maximum length: Mesh ID body offset lands on 2048 and wraps to zero
		start_header(ACT_OPEN);
		add_element(EID_PEER_MGMT, 4);
		fill_to(FRAME_LIMIT - 2);
		add_element(EID_MESH_ID, 0);
		send_frame();

		// one byte over the limit, then well past it (counter saturates)
		start_header(ACT_OPEN);
		add_element(EID_PEER_MGMT, 4);
		fill_to(FRAME_LIMIT + 1);
		send_frame();
		start_header(ACT_CLOSE);
		add_element(EID_PEER_MGMT, 6);
		fill_to(FRAME_LIMIT + 20);
		send_frame();

		// --- random frames ---
		base = bytes_sent;
		run_random(base + 700, 0);
		// a stretch with no idling on either side
		idle_pct = 0;
		run_random(base + 1100, 0);
		idle_pct = 16;
		// receiver holds off while frames keep coming, so the parser backs up
		hold_request = 1;
		run_random(base + 1500, 0);
		// sender waits for every decode before going on
		drain();
		run_random(base + 2000, 60);

		drain();
		repeat (10) @(negedge clk);
		if (decode_chk.errors == 0 && decode_chk.pending() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

// ===== mesh_peering_frame_parser.f =====
rtl/mpfp_pkg.sv
rtl/mpfp_parse.sv
rtl/mesh_peering_frame_parser.sv
test/testbench.sv
